// File: hdl/lphi_pkg.sv
// shared types, codes and constants for the linear probe hash index
`default_nettype none
package lphi_pkg;

	localparam int TABLE_SLOTS_DEF = 1024;
	localparam int LIMIT_W = 10;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd716;
	localparam int MOD_BITS = 8;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key_id;
		logic [63:0] log_offset;
		logic [31:0] record_length;
		logic [7:0]  record_type;
		logic        tombstone;
		logic [63:0] expiry_time;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] found_offset;
		logic [31:0] found_length;
		logic [7:0]  found_type;
		logic [63:0] found_expiry;
	} out_t;

	typedef struct packed {
		logic        used;
		logic [63:0] key;
		logic [63:0] offset;
		logic [31:0] length;
		logic [7:0]  rec_type;
		logic        deleted;
		logic [63:0] expiry;
	} slot_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic rd;
		logic chk;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic stop;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/lphi_ram.sv
// generic single write port ram with registered read
`default_nettype none
module lphi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/lphi_hash.sv
// iterative id mixer and home slot reduction
`default_nettype none
module lphi_hash #(
	parameter int TABLE_SLOTS = lphi_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [63:0]                    key,
	output logic                                done,
	output logic      [$clog2(TABLE_SLOTS)-1:0] slot
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam int MUL_STEPS = 8;
	localparam int MOD_STEPS = 64 / lphi_pkg::MOD_BITS;
	localparam int LAST = POW2 ? MUL_STEPS : MUL_STEPS + MOD_STEPS;
	localparam int STP_W = $clog2(LAST + 1);

	logic             act_q;
	logic [STP_W-1:0] stp_q;
	logic [63:0]      x_q;
	logic [63:0]      lo_q;
	logic [31:0]      cr_q;
	logic [SW-1:0]    rem_q;

	logic [63:0]   cst;
	logic [31:0]   op_a;
	logic [31:0]   op_b;
	logic [63:0]   prod;
	logic [63:0]   y;
	logic [63:0]   mixed;
	logic          mul_ph;
	logic          mod_ph;
	logic [SW-1:0] rem_nxt;

	assign mul_ph = stp_q < STP_W'(MUL_STEPS);
	assign mod_ph = !mul_ph && (stp_q < STP_W'(LAST));
	assign cst = stp_q[2] ? lphi_pkg::MIX_C2 : lphi_pkg::MIX_C1;
	assign op_a = (stp_q[1:0] == 2'd1) ? x_q[63:32] : x_q[31:0];
	assign op_b = (stp_q[1:0] == 2'd2) ? cst[63:32] : cst[31:0];
	assign prod = 64'(op_a) * 64'(op_b);
	assign y = lo_q + {cr_q, 32'b0};
	assign mixed = stp_q[2] ? (y ^ (y >> 31)) : (y ^ (y >> 27));

	always_comb begin
		logic [SW:0]   t;
		logic [SW-1:0] r;
		r = rem_q;
		for (int i = 0; i < lphi_pkg::MOD_BITS; i++) begin
			t = {r, x_q[63-i]};
			if (t >= (SW+1)'(TABLE_SLOTS)) begin
				t = t - (SW+1)'(TABLE_SLOTS);
			end
			r = t[SW-1:0];
		end
		rem_nxt = r;
	end

	assign done = act_q && (stp_q == STP_W'(LAST));
	assign slot = POW2 ? x_q[SW-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			stp_q <= '0;
		end else if (start) begin
			act_q <= 1'b1;
			stp_q <= '0;
		end else if (act_q) begin
			if (done) begin
				act_q <= 1'b0;
			end else begin
				stp_q <= stp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= key ^ (key >> 30);
			rem_q <= '0;
		end else if (act_q && mul_ph) begin
			case (stp_q[1:0])
				2'd0: lo_q <= prod;
				2'd1: cr_q <= prod[31:0];
				2'd2: cr_q <= cr_q + prod[31:0];
				2'd3: x_q <= mixed;
				default: lo_q <= prod;
			endcase
		end else if (act_q && mod_ph) begin
			x_q <= x_q << lphi_pkg::MOD_BITS;
			rem_q <= rem_nxt;
		end
	end

endmodule
`default_nettype wire

// File: hdl/lphi_ctrl.sv
// control state machine: table clear, hash, probe read and check
`default_nettype none
module lphi_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire lphi_pkg::sts_t sts,
	output logic                busy,
	output lphi_pkg::ctl_t      ctl
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_RD    = 5'b01000,
		S_CHK   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.take = 1'b1;
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					state_nxt = S_RD;
				end
			end
			S_RD: begin
				ctl.rd = 1'b1;
				state_nxt = S_CHK;
			end
			S_CHK: begin
				ctl.chk = 1'b1;
				state_nxt = sts.stop ? S_IDLE : S_RD;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_HASH))
		else $error("accepted beat did not enter hash");

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> ($past(state_q) == S_RD))
		else $error("check without preceding read");

endmodule
`default_nettype wire

// File: hdl/lphi_dp.sv
// datapath: slot table, probe pointer, entry count and result register
`default_nettype none
module lphi_dp #(
	parameter int TABLE_SLOTS = lphi_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lphi_pkg::ctl_t                   ctl,
	output lphi_pkg::sts_t                        sts,
	input  wire lphi_pkg::in_t                    item,
	input  wire logic                             cfg_we,
	input  wire logic [lphi_pkg::LIMIT_W-1:0]     cfg_wdata,
	output logic                                  done,
	output lphi_pkg::out_t                        result
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int LW = lphi_pkg::LIMIT_W;
	localparam int LMAX = (1 << LW) - 1;
	localparam int CAP = (TABLE_SLOTS - 1 < LMAX) ? TABLE_SLOTS - 1 : LMAX;

	lphi_pkg::in_t  item_q;
	lphi_pkg::out_t res_q;
	logic           done_q;
	logic [LW-1:0]  limit_q;
	logic [LW-1:0]  count_q;
	logic [SW-1:0]  pos_q;
	logic [SW-1:0]  clr_q;

	logic                   hash_done;
	logic [SW-1:0]          hash_slot;
	logic [$bits(lphi_pkg::slot_t)-1:0] rdata;
	lphi_pkg::slot_t        row;
	lphi_pkg::slot_t        wrow;
	logic                   we;
	logic [SW-1:0]          waddr;
	logic [LW-1:0]          eff_lim;
	logic                   at_lim;
	logic                   is_put;
	logic                   ins;
	lphi_pkg::out_t         res_nxt;

	lphi_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.take),
		.key    (item.key_id),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	lphi_ram #(.WIDTH($bits(lphi_pkg::slot_t)), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrow),
		.re    (ctl.rd),
		.raddr (pos_q),
		.rdata (rdata)
	);

	assign row = lphi_pkg::slot_t'(rdata);
	assign eff_lim = (limit_q > LW'(CAP)) ? LW'(CAP) : limit_q;
	assign at_lim = (count_q >= eff_lim);
	assign is_put = (item_q.cmd == lphi_pkg::CMD_PUT);
	assign ins = ctl.chk && sts.stop && is_put && !row.used && !at_lim;

	assign sts.stop = !row.used || (row.key == item_q.key_id);
	assign sts.hash_done = hash_done;
	assign sts.clr_last = (clr_q == SW'(TABLE_SLOTS - 1));

	always_comb begin
		wrow.used = 1'b1;
		wrow.key = item_q.key_id;
		wrow.offset = item_q.log_offset;
		wrow.length = item_q.record_length;
		wrow.rec_type = item_q.record_type;
		wrow.deleted = item_q.tombstone;
		wrow.expiry = item_q.expiry_time;
		we = 1'b0;
		waddr = pos_q;
		if (ctl.clr) begin
			we = 1'b1;
			waddr = clr_q;
			wrow = '0;
		end else if (ctl.chk && sts.stop && is_put && (row.used || !at_lim)) begin
			we = 1'b1;
		end
	end

	always_comb begin
		res_nxt = '0;
		res_nxt.status = lphi_pkg::ST_OK;
		if (is_put) begin
			if (!row.used && at_lim) begin
				res_nxt.status = lphi_pkg::ST_FULL;
			end
		end else if (!row.used || row.deleted) begin
			res_nxt.status = lphi_pkg::ST_MISS;
		end else begin
			res_nxt.found_offset = row.offset;
			res_nxt.found_length = row.length;
			res_nxt.found_type = row.rec_type;
			res_nxt.found_expiry = row.expiry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			limit_q <= lphi_pkg::LIMIT_RESET;
			count_q <= '0;
			clr_q <= '0;
		end else begin
			done_q <= ctl.chk && sts.stop;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (ins) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.clr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			item_q <= item;
		end
		if (hash_done) begin
			pos_q <= hash_slot;
		end else if (ctl.chk && !sts.stop) begin
			pos_q <= (pos_q == SW'(TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;
		end
		if (ctl.chk && sts.stop) begin
			res_q <= res_nxt;
		end
	end

	assign done = done_q;
	assign result = res_q;

	a_no_double_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result beats back to back");

	a_full_is_put: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == lphi_pkg::ST_FULL) |-> (item_q.cmd == lphi_pkg::CMD_PUT))
		else $error("full status on a get");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(CAP))
		else $error("entry count above table capacity");

endmodule
`default_nettype wire

// File: hdl/linear_probe_hash_index_core.sv
// top level of the linear probe hash index
//
//  channel   signals                  handshake
//  input     start, busy, item        beat taken when start && !busy
//  result    done, result             one beat per item, done high one cycle
//  config    cfg_we, cfg_wdata        entry limit written when cfg_we
//
//  after reset the table is swept clear slot by slot, with busy high
//  the mixer shares one 32x32 multiplier; for sizes that are not a power of
//  two the home slot reduction follows at 8 bits a cycle, then one table read
//  per probe; busy stays high until the result, so items do not overlap
//  done rises the cycle after the last probe check; the receiver cannot stall
`default_nettype none
module linear_probe_hash_index_core #(
	parameter int TABLE_SLOTS = lphi_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire lphi_pkg::in_t                item,
	output logic                              done,
	output lphi_pkg::out_t                    result,
	input  wire logic                         cfg_we,
	input  wire logic [lphi_pkg::LIMIT_W-1:0] cfg_wdata
);

	lphi_pkg::ctl_t ctl;
	lphi_pkg::sts_t sts;

	lphi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	lphi_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire
